FILE: rtl/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational reduce block
// Operand widths, command and status codes, and the front-to-back job type.
// ----------------------------------------------------------------------------
package rar_pkg;
   localparam int OperandWidth = 16;
   localparam int NumWidth     = 2 * OperandWidth + 1;
   localparam int DenWidth     = 2 * OperandWidth;
   localparam int QueueDepth   = 2;

   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_DIFF = 2'd1;
   localparam logic [1:0] CMD_MUL  = 2'd2;
   localparam logic [1:0] CMD_DIV  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

   // classified job handed from front to back
   typedef struct packed {
      logic [1:0]                command;
      logic [OperandWidth-1:0]   a_numerator;
      logic [OperandWidth-1:0]   a_denominator;
      logic [OperandWidth-1:0]   b_numerator;
      logic [OperandWidth-1:0]   b_denominator;
      logic [1:0]                status;
   } job_type;
endpackage

FILE: rtl/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front: input stage and job queue
// Accepts items, flags zero denominators and division by zero, and queues jobs.
// ----------------------------------------------------------------------------
module rar_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [rar_pkg::OperandWidth-1:0] req_a_numerator,
   input  logic [rar_pkg::OperandWidth-1:0] req_a_denominator,
   input  logic [rar_pkg::OperandWidth-1:0] req_b_numerator,
   input  logic [rar_pkg::OperandWidth-1:0] req_b_denominator,
   output logic                          job_valid,
   input  logic                          job_take,
   output rar_pkg::job_type              job
);
   import rar_pkg::*;

   job_type    slot_ff [QueueDepth];
   job_type    new_job;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // classify the incoming item
   always_comb begin
      new_job.command       = req_command;
      new_job.a_numerator   = req_a_numerator;
      new_job.a_denominator = req_a_denominator;
      new_job.b_numerator   = req_b_numerator;
      new_job.b_denominator = req_b_denominator;
      if (req_a_denominator == '0 || req_b_denominator == '0) begin
         new_job.status = STATUS_ZERO_DEN;
      end else if (req_command == CMD_DIV && req_b_numerator == '0) begin
         new_job.status = STATUS_DIV_ZERO;
      end else begin
         new_job.status = STATUS_OK;
      end
   end

   assign req_stall = (count_ff == 2'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != 2'd0);
   assign job       = slot_ff[rd_ptr_ff];

   // advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ job_take;
      count_in  = count_ff + 2'(push) - 2'(job_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_job;
      end
   end
endmodule

FILE: rtl/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back: cross products, GCD and reduction sequencer
// Forms the unreduced fraction, finds the GCD by binary steps and divides
// both terms by it with a shared restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module rar_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   output logic                               job_take,
   input  rar_pkg::job_type                   job,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rar_pkg::NumWidth-1:0]       rsp_result_numerator,
   output logic [rar_pkg::DenWidth-1:0]       rsp_result_denominator,
   output logic [1:0]                         rsp_status
);
   import rar_pkg::*;

   localparam int CntWidth = $clog2(NumWidth + 1);
   localparam int ProdWidth = 2 * OperandWidth;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_GCD  = 3'd3;
   localparam logic [2:0] ST_DIVN = 3'd4;
   localparam logic [2:0] ST_DIVD = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            cmd_ff;
   logic [1:0]            job_st_ff;
   logic [ProdWidth-1:0]  p0_ff, p1_ff, p2_ff;
   logic [NumWidth-1:0]   num_ff, num_in;
   logic [DenWidth-1:0]   den_ff, den_in;
   logic [NumWidth-1:0]   gu_ff, gu_in, gv_ff, gv_in;
   logic [CntWidth-1:0]   shift_ff, shift_in;
   logic [NumWidth-1:0]   g_ff;
   logic [NumWidth-1:0]   dq_ff, dq_in, dr_ff, dr_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic [NumWidth:0]     trial;
   logic [NumWidth-1:0]   rem_shift;
   logic [NumWidth-1:0]   o_num_ff;
   logic [DenWidth-1:0]   o_den_ff;
   logic [1:0]            o_st_ff;
   logic                  o_valid_ff;
   logic                  load_out;
   logic [NumWidth-1:0]   sum_x, sum_y;

   assign job_take = (state_ff == ST_IDLE) && job_valid;

   // one restoring divide step on dq/dr by g
   assign rem_shift = {dr_ff[NumWidth-2:0], dq_ff[NumWidth-1]};
   assign trial     = {1'b0, rem_shift} - {1'b0, g_ff};
   assign sum_x     = NumWidth'(p0_ff);
   assign sum_y     = NumWidth'(p1_ff);

   // sequence one job
   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      gu_in    = gu_ff;
      gv_in    = gv_ff;
      shift_in = shift_ff;
      dq_in    = dq_ff;
      dr_in    = dr_ff;
      cnt_in   = cnt_ff;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = (job.status == STATUS_OK) ? ST_MUL : ST_OUT;
               // flagged items report 0/0
               if (job.status != STATUS_OK) begin
                  num_in = '0;
                  den_in = '0;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            case (cmd_ff)
               CMD_ADD:  num_in = sum_x + sum_y;
               CMD_DIFF: num_in = (sum_x > sum_y) ? sum_x - sum_y : sum_y - sum_x;
               CMD_MUL:  num_in = sum_x;
               default:  num_in = sum_x;
            endcase
            den_in   = p2_ff;
            gu_in    = num_in;
            gv_in    = NumWidth'(p2_ff);
            shift_in = '0;
            state_in = (num_in == '0) ? ST_OUT : ST_GCD;
            if (num_in == '0) begin
               den_in = DenWidth'(1);
            end
         end
         ST_GCD: begin
            // binary GCD step: strip common twos, then odd-odd subtract
            if (gu_ff == gv_ff) begin
               dq_in    = num_ff;
               dr_in    = '0;
               cnt_in   = CntWidth'(NumWidth);
               state_in = ST_DIVN;
            end else if (!gu_ff[0] && !gv_ff[0]) begin
               gu_in    = gu_ff >> 1;
               gv_in    = gv_ff >> 1;
               shift_in = shift_ff + 1'b1;
            end else if (!gu_ff[0]) begin
               gu_in = gu_ff >> 1;
            end else if (!gv_ff[0]) begin
               gv_in = gv_ff >> 1;
            end else if (gu_ff > gv_ff) begin
               gu_in = (gu_ff - gv_ff) >> 1;
            end else begin
               gv_in = (gv_ff - gu_ff) >> 1;
            end
         end
         ST_DIVN, ST_DIVD: begin
            dq_in = {dq_ff[NumWidth-2:0], ~trial[NumWidth]};
            dr_in = trial[NumWidth] ? rem_shift : trial[NumWidth-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntWidth'(1)) begin
               if (state_ff == ST_DIVN) begin
                  num_in   = dq_in;
                  dq_in    = NumWidth'(den_ff);
                  dr_in    = '0;
                  cnt_in   = CntWidth'(NumWidth);
                  state_in = ST_DIVD;
               end else begin
                  den_in   = DenWidth'(dq_in);
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!o_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            o_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      gu_ff    <= gu_in;
      gv_ff    <= gv_in;
      shift_ff <= shift_in;
      dq_ff    <= dq_in;
      dr_ff    <= dr_in;
      cnt_ff   <= cnt_in;
      if (state_ff == ST_GCD && gu_ff == gv_ff) begin
         g_ff <= gu_ff << shift_ff;
      end
      // capture the cross products of a new job
      if (job_take) begin
         cmd_ff    <= job.command;
         job_st_ff <= job.status;
         p0_ff <= (job.command == CMD_MUL) ?
                  ProdWidth'(job.a_numerator) * ProdWidth'(job.b_numerator) :
                  ProdWidth'(job.a_numerator) * ProdWidth'(job.b_denominator);
         p1_ff <= ProdWidth'(job.a_denominator) * ProdWidth'(job.b_numerator);
         p2_ff <= (job.command == CMD_DIV) ?
                  ProdWidth'(job.a_denominator) * ProdWidth'(job.b_numerator) :
                  ProdWidth'(job.a_denominator) * ProdWidth'(job.b_denominator);
      end
      if (load_out) begin
         o_num_ff <= num_ff;
         o_den_ff <= den_ff;
         o_st_ff  <= job_st_ff;
      end
   end

   assign rsp_valid              = o_valid_ff;
   assign rsp_result_numerator   = o_num_ff;
   assign rsp_result_denominator = o_den_ff;
   assign rsp_status             = o_st_ff;
endmodule

FILE: rtl/rational_arithmetic_reduce.sv
// The run time of an item is set by the binary GCD loop and by two 33-step
// bit-serial divides sharing one subtractor; flagged items and zero results
// skip both.
// Throughput: one item at a time in the back end; a two-entry job queue lets
// new items be accepted while one is in progress.
// Reset: synchronous, active high; clears the queue and sequencer, no sweep.
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce: fraction add, difference, multiply and divide
// Reduces the result to lowest terms and reports denominator errors.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_command,
   input  logic [rar_pkg::OperandWidth-1:0]      req_a_numerator,
   input  logic [rar_pkg::OperandWidth-1:0]      req_a_denominator,
   input  logic [rar_pkg::OperandWidth-1:0]      req_b_numerator,
   input  logic [rar_pkg::OperandWidth-1:0]      req_b_denominator,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rar_pkg::NumWidth-1:0]          rsp_result_numerator,
   output logic [rar_pkg::DenWidth-1:0]          rsp_result_denominator,
   output logic [1:0]                            rsp_status
);
   import rar_pkg::*;

   logic    job_valid, job_take;
   job_type job;

   // accept and classify
   rar_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_command,
      .req_a_numerator, .req_a_denominator, .req_b_numerator,
      .req_b_denominator, .job_valid, .job_take, .job
   );

   // compute and reduce
   rar_back u_back (
      .clock, .reset, .job_valid, .job_take, .job, .rsp_valid, .rsp_stall,
      .rsp_result_numerator, .rsp_result_denominator, .rsp_status
   );
endmodule
